// File: rtl/rpp_pkg.sv
`default_nettype none

package rpp_pkg;

    // Field widths
    localparam int C_COORD_BITS  = 16;
    localparam int C_DIM_BITS    = 16;
    localparam int C_PITCH_BITS  = 18;
    localparam int C_BPP_BITS    = 3;
    localparam int C_FMT_BITS    = 9;
    localparam int C_RGB_BITS    = 24;
    localparam int C_COMP_BITS   = 8;
    localparam int C_SIZE_BITS   = 4;
    localparam int C_POS_BITS    = 5;
    localparam int C_PROD_BITS   = 2 * C_COMP_BITS;
    localparam int C_WORD_BITS   = 32;
    localparam int C_OFFSET_BITS = 34;

    // Configuration port
    localparam int C_CFG_IDX_BITS  = 3;
    localparam int C_CFG_DATA_BITS = 18;

    // Derived arithmetic widths
    localparam int C_CMP_BITS = (C_COORD_BITS > C_DIM_BITS) ? C_COORD_BITS : C_DIM_BITS;
    localparam int C_YP_BITS  = C_COORD_BITS + C_PITCH_BITS;
    localparam int C_XB_BITS  = C_COORD_BITS + C_BPP_BITS;
    localparam int C_SUM_BITS = (C_YP_BITS + 1 > C_OFFSET_BITS) ? C_YP_BITS + 1 : C_OFFSET_BITS;

    // Clamp limits and reset values
    localparam logic [C_BPP_BITS-1:0]  C_BPP_MIN       = 3'd2;
    localparam logic [C_BPP_BITS-1:0]  C_BPP_MAX       = 3'd4;
    localparam logic [C_SIZE_BITS-1:0] C_SIZE_MAX      = 4'd8;
    localparam logic [C_BPP_BITS-1:0]  C_RST_BPP       = 3'd4;
    localparam logic [C_FMT_BITS-1:0]  C_RST_RED_FMT   = 9'd264;
    localparam logic [C_FMT_BITS-1:0]  C_RST_GREEN_FMT = 9'd136;
    localparam logic [C_FMT_BITS-1:0]  C_RST_BLUE_FMT  = 9'd8;

    typedef logic [C_CMP_BITS-1:0]    t_cmp;
    typedef logic [C_SUM_BITS-1:0]    t_sum;
    typedef logic [C_OFFSET_BITS-1:0] t_offset;
    typedef logic [C_WORD_BITS-1:0]   t_word;

    typedef enum logic [C_CFG_IDX_BITS-1:0] {
        CFG_SCREEN_WIDTH    = 3'd0,
        CFG_SCREEN_HEIGHT   = 3'd1,
        CFG_LINE_PITCH      = 3'd2,
        CFG_BYTES_PER_PIXEL = 3'd3,
        CFG_RED_FORMAT      = 3'd4,
        CFG_GREEN_FORMAT    = 3'd5,
        CFG_BLUE_FORMAT     = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [C_COORD_BITS-1:0] pos_x;
        logic [C_COORD_BITS-1:0] pos_y;
        logic [C_RGB_BITS-1:0]   colour_rgb;
    } t_in_item;

    typedef struct packed {
        logic [C_OFFSET_BITS-1:0] byte_offset;
        logic [C_WORD_BITS-1:0]   pixel_word;
        logic [C_BPP_BITS-1:0]    byte_count;
    } t_out_item;

    typedef struct packed {
        logic [C_DIM_BITS-1:0]   screen_width;
        logic [C_DIM_BITS-1:0]   screen_height;
        logic [C_PITCH_BITS-1:0] line_pitch;
        logic [C_BPP_BITS-1:0]   bytes_per_pixel;
        logic [C_FMT_BITS-1:0]   red_format;
        logic [C_FMT_BITS-1:0]   green_format;
        logic [C_FMT_BITS-1:0]   blue_format;
    } t_cfg;

    // Stage 1 -> 2: raw products
    typedef struct packed {
        logic [C_YP_BITS-1:0]   y_pitch;
        logic [C_XB_BITS-1:0]   x_bpp;
        logic [C_PROD_BITS-1:0] prod_r;
        logic [C_PROD_BITS-1:0] prod_g;
        logic [C_PROD_BITS-1:0] prod_b;
        logic [C_POS_BITS-1:0]  pos_r;
        logic [C_POS_BITS-1:0]  pos_g;
        logic [C_POS_BITS-1:0]  pos_b;
        logic [C_BPP_BITS-1:0]  bpp;
    } t_s1;

    // Stage 2 -> 3: offset done, components rescaled
    typedef struct packed {
        logic [C_OFFSET_BITS-1:0] byte_offset;
        logic [C_COMP_BITS-1:0]   scaled_r;
        logic [C_COMP_BITS-1:0]   scaled_g;
        logic [C_COMP_BITS-1:0]   scaled_b;
        logic [C_POS_BITS-1:0]    pos_r;
        logic [C_POS_BITS-1:0]    pos_g;
        logic [C_POS_BITS-1:0]    pos_b;
        logic [C_BPP_BITS-1:0]    bpp;
    } t_s2;

    // 2^size-1, or zero for an unusable size
    function automatic logic [C_COMP_BITS-1:0] size_mask(input logic [C_SIZE_BITS-1:0] size);
        logic [C_COMP_BITS:0] m;
        m = (9'd1 << size) - 9'd1;
        if (size == '0 || size > C_SIZE_MAX) begin
            return '0;
        end
        return m[C_COMP_BITS-1:0];
    endfunction

    // p / 255 for p <= 255*255: (p + (p >> 8) + 1) >> 8
    function automatic logic [C_COMP_BITS-1:0] div255(input logic [C_PROD_BITS-1:0] p);
        logic [C_PROD_BITS:0] t;
        t = {1'b0, p} + {{(C_COMP_BITS+1){1'b0}}, p[C_PROD_BITS-1:C_COMP_BITS]}
            + {{C_PROD_BITS{1'b0}}, 1'b1};
        return t[C_PROD_BITS-1:C_COMP_BITS];
    endfunction

endpackage

`default_nettype wire

// File: rtl/rpp_cfg_regs.sv
`default_nettype none

module rpp_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rpp_pkg::C_CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [rpp_pkg::C_CFG_DATA_BITS-1:0] i_cfg_data,
    output rpp_pkg::t_cfg                           o_cfg
);

    rpp_pkg::t_cfg r_cfg;
    rpp_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (rpp_pkg::t_cfg_idx'(i_cfg_index))
                rpp_pkg::CFG_SCREEN_WIDTH: begin
                    n_cfg.screen_width = i_cfg_data[rpp_pkg::C_DIM_BITS-1:0];
                end
                rpp_pkg::CFG_SCREEN_HEIGHT: begin
                    n_cfg.screen_height = i_cfg_data[rpp_pkg::C_DIM_BITS-1:0];
                end
                rpp_pkg::CFG_LINE_PITCH: begin
                    n_cfg.line_pitch = i_cfg_data[rpp_pkg::C_PITCH_BITS-1:0];
                end
                rpp_pkg::CFG_BYTES_PER_PIXEL: begin
                    n_cfg.bytes_per_pixel = i_cfg_data[rpp_pkg::C_BPP_BITS-1:0];
                end
                rpp_pkg::CFG_RED_FORMAT: begin
                    n_cfg.red_format = i_cfg_data[rpp_pkg::C_FMT_BITS-1:0];
                end
                rpp_pkg::CFG_GREEN_FORMAT: begin
                    n_cfg.green_format = i_cfg_data[rpp_pkg::C_FMT_BITS-1:0];
                end
                rpp_pkg::CFG_BLUE_FORMAT: begin
                    n_cfg.blue_format = i_cfg_data[rpp_pkg::C_FMT_BITS-1:0];
                end
                default: begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width    <= '0;
            r_cfg.screen_height   <= '0;
            r_cfg.line_pitch      <= '0;
            r_cfg.bytes_per_pixel <= rpp_pkg::C_RST_BPP;
            r_cfg.red_format      <= rpp_pkg::C_RST_RED_FMT;
            r_cfg.green_format    <= rpp_pkg::C_RST_GREEN_FMT;
            r_cfg.blue_format     <= rpp_pkg::C_RST_BLUE_FMT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/rpp_mul_stage.sv
`default_nettype none

module rpp_mul_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire rpp_pkg::t_in_item i_item,
    input  wire rpp_pkg::t_cfg i_cfg,
    output logic               o_valid,
    output rpp_pkg::t_s1       o_s1
);

    logic                 r_valid;
    rpp_pkg::t_s1         r_s1;
    rpp_pkg::t_s1         n_s1;
    logic                 visible;
    logic [rpp_pkg::C_BPP_BITS-1:0] bpp;

    always_comb begin
        visible = (rpp_pkg::t_cmp'(i_item.pos_x) < rpp_pkg::t_cmp'(i_cfg.screen_width))
               && (rpp_pkg::t_cmp'(i_item.pos_y) < rpp_pkg::t_cmp'(i_cfg.screen_height));

        if (i_cfg.bytes_per_pixel < rpp_pkg::C_BPP_MIN) begin
            bpp = rpp_pkg::C_BPP_MIN;
        end else if (i_cfg.bytes_per_pixel > rpp_pkg::C_BPP_MAX) begin
            bpp = rpp_pkg::C_BPP_MAX;
        end else begin
            bpp = i_cfg.bytes_per_pixel;
        end

        n_s1.y_pitch = rpp_pkg::C_YP_BITS'(i_item.pos_y) * rpp_pkg::C_YP_BITS'(i_cfg.line_pitch);
        n_s1.x_bpp   = rpp_pkg::C_XB_BITS'(i_item.pos_x) * rpp_pkg::C_XB_BITS'(bpp);
        n_s1.prod_r  = rpp_pkg::C_PROD_BITS'(i_item.colour_rgb[23:16])
                     * rpp_pkg::C_PROD_BITS'(rpp_pkg::size_mask(i_cfg.red_format[3:0]));
        n_s1.prod_g  = rpp_pkg::C_PROD_BITS'(i_item.colour_rgb[15:8])
                     * rpp_pkg::C_PROD_BITS'(rpp_pkg::size_mask(i_cfg.green_format[3:0]));
        n_s1.prod_b  = rpp_pkg::C_PROD_BITS'(i_item.colour_rgb[7:0])
                     * rpp_pkg::C_PROD_BITS'(rpp_pkg::size_mask(i_cfg.blue_format[3:0]));
        n_s1.pos_r   = i_cfg.red_format[8:4];
        n_s1.pos_g   = i_cfg.green_format[8:4];
        n_s1.pos_b   = i_cfg.blue_format[8:4];
        n_s1.bpp     = bpp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && visible;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1 <= n_s1;
        end
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

`default_nettype wire

// File: rtl/rpp_scale_stage.sv
`default_nettype none

module rpp_scale_stage (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_en,
    input  wire logic     i_valid,
    input  wire rpp_pkg::t_s1 i_s1,
    output logic          o_valid,
    output rpp_pkg::t_s2  o_s2
);

    logic          r_valid;
    rpp_pkg::t_s2  r_s2;
    rpp_pkg::t_s2  n_s2;
    rpp_pkg::t_sum sum;

    always_comb begin
        sum = rpp_pkg::t_sum'(i_s1.y_pitch) + rpp_pkg::t_sum'(i_s1.x_bpp);
        n_s2.byte_offset = sum[rpp_pkg::C_OFFSET_BITS-1:0];
        n_s2.scaled_r    = rpp_pkg::div255(i_s1.prod_r);
        n_s2.scaled_g    = rpp_pkg::div255(i_s1.prod_g);
        n_s2.scaled_b    = rpp_pkg::div255(i_s1.prod_b);
        n_s2.pos_r       = i_s1.pos_r;
        n_s2.pos_g       = i_s1.pos_g;
        n_s2.pos_b       = i_s1.pos_b;
        n_s2.bpp         = i_s1.bpp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2 <= n_s2;
        end
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire

// File: rtl/rpp_pack_stage.sv
`default_nettype none

module rpp_pack_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire rpp_pkg::t_s2  i_s2,
    output logic               o_valid,
    output rpp_pkg::t_out_item o_item
);

    logic               r_valid;
    rpp_pkg::t_out_item r_item;
    rpp_pkg::t_out_item n_item;

    always_comb begin
        // bits shifted past the top of the word are dropped
        n_item.pixel_word  = (rpp_pkg::t_word'(i_s2.scaled_r) << i_s2.pos_r)
                           | (rpp_pkg::t_word'(i_s2.scaled_g) << i_s2.pos_g)
                           | (rpp_pkg::t_word'(i_s2.scaled_b) << i_s2.pos_b);
        n_item.byte_offset = i_s2.byte_offset;
        n_item.byte_count  = i_s2.bpp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// File: rtl/rgb_pixel_packer_top.sv
// Path: an accepted item is registered in stage 1, then stage 2, then stage 3, which is the output register.
// Throughput: one item per cycle; the three stages advance together unless a
// result waits in the output register under stall.
// Reset: synchronous, active low; clears all stage valid bits and loads the
// configuration reset values (width/height/pitch 0, 4 bytes per pixel, 8:8:8 at 16/8/0).
`default_nettype none

module rgb_pixel_packer_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [rpp_pkg::C_CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [rpp_pkg::C_CFG_DATA_BITS-1:0] i_cfg_data,
    // input items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire rpp_pkg::t_in_item                   i_in_data,
    // result items
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output rpp_pkg::t_out_item                       o_out_data
);

    rpp_pkg::t_cfg      cfg;
    rpp_pkg::t_s1       s1;
    rpp_pkg::t_s2       s2;
    rpp_pkg::t_out_item out_item;
    logic               s1_valid;
    logic               s2_valid;
    logic               s3_valid;
    logic               en;

    // Whole pipe moves as one unless a finished result is held at the output.
    // Bubbles and dropped (off-screen) items ride along as cleared valid bits.
    assign en         = !(s3_valid && i_out_stall);
    assign o_in_stall = !en;

    rpp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Stage 1: bounds check, bpp clamp, y*pitch, x*bpp, component*mask
    rpp_mul_stage u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_cfg   (cfg),
        .o_valid (s1_valid),
        .o_s1    (s1)
    );

    // Stage 2: offset sum, divide by 255 via reciprocal trick
    rpp_scale_stage u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .o_s2    (s2)
    );

    // Stage 3: shift into position and OR; doubles as the output register
    rpp_pack_stage u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s2_valid),
        .i_s2    (s2),
        .o_valid (s3_valid),
        .o_item  (out_item)
    );

    assign o_out_valid = s3_valid;
    assign o_out_data  = out_item;

endmodule

`default_nettype wire
